### rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Types, codes and constants shared by the paired-single quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

   localparam int NUM_QREGS  = 8;
   localparam int QSEL_WIDTH = $clog2(NUM_QREGS);
   localparam int NUM_LANES  = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   localparam logic [2:0] QT_FLOAT = 3'd0;
   localparam logic [2:0] QT_U8    = 3'd4;
   localparam logic [2:0] QT_U16   = 3'd5;
   localparam logic [2:0] QT_S8    = 3'd6;
   localparam logic [2:0] QT_S16   = 3'd7;

   localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_TYPE = 2'd1,
      ERR_NAN  = 2'd2
   } psq_err_type;

   typedef struct packed {
      logic        cmd;
      logic        single_value;
      logic [2:0]  quant_select;
      logic [4:0]  fpr_index;
      logic [31:0] address;
      logic [63:0] load_data;
      logic [63:0] first_in;
      logic [63:0] second_in;
   } psq_req_type;

   typedef struct packed {
      logic [4:0]  dest_index;
      logic [31:0] access_address;
      logic [63:0] first_out;
      logic [63:0] second_out;
      logic [63:0] store_data;
      logic [3:0]  store_bytes;
      logic [1:0]  fault_code;
   } psq_rsp_type;

   typedef struct packed {
      logic              store;
      logic [2:0]        qtype;
      logic signed [5:0] scale;
   } psq_lane_ctl_type;

   typedef struct packed {
      logic [63:0] dbl;
      logic [31:0] word;
      logic        nan;
   } psq_lane_res_type;

endpackage

`default_nettype wire

### rtl/psq_lane.sv
// ----------------------------------------------------------------------------
// psq_lane
// One value: dequantize a load word into a double, or quantize a double
// into a store word.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_lane (
   input  psq_pkg::psq_lane_ctl_type ctl,
   input  logic [31:0]               load_word,
   input  logic [63:0]               store_val,
   output psq_pkg::psq_lane_res_type res
);
   import psq_pkg::*;

   function automatic logic [4:0] msb23(input logic [22:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (v[i]) begin
            r = i[4:0];
         end
      end
      return r;
   endfunction

   // round to nearest even, results below the normal range become zero
   function automatic logic [31:0] dbl_to_flt(input logic [63:0] d);
      logic              s;
      logic [10:0]       e;
      logic [51:0]       m;
      logic signed [12:0] fe;
      logic              up;
      logic [30:0]       sum;
      logic [31:0]       r;
      s  = d[63];
      e  = d[62:52];
      m  = d[51:0];
      fe = $signed({2'b00, e}) - 13'sd896;
      up = m[28] & ((|m[27:0]) | m[29]);
      sum = {fe[7:0], m[51:29]} + {30'd0, up};
      if (e == 11'h7FF || fe >= 13'sd255) begin
         r = {s, 8'hFF, 23'd0};
      end else if (e == 11'd0) begin
         r = {s, 31'd0};
      end else if (fe >= 13'sd1) begin
         r = {s, sum};
      end else if (fe == 13'sd0 && (&m[51:29])) begin
         r = {s, 8'd1, 23'd0};
      end else begin
         r = {s, 31'd0};
      end
      return r;
   endfunction

   logic signed [16:0] ival;
   logic [16:0]        iabs;
   logic               ineg;
   logic [15:0]        imag;
   logic [4:0]         ip;
   logic signed [6:0]  kval;
   logic [10:0]        iexp;
   logic [52:0]        ish;
   logic [63:0]        idbl;

   logic [7:0]         lex;
   logic [22:0]        lman;
   logic [4:0]         lp;
   logic [52:0]        lsh;
   logic [63:0]        fdbl;

   logic               snan;
   logic [31:0]        sflt;
   logic [31:0]        fword;
   logic signed [9:0]  ue;
   logic               huge;
   logic               tiny;
   logic [23:0]        sig;
   logic [4:0]         shamt;
   logic [23:0]        msh;
   logic [15:0]        smag;
   logic               sneg;
   logic [15:0]        iword;

   // load, integer types
   always_comb begin
      case (ctl.qtype)
         QT_U8:   ival = $signed({9'd0, load_word[7:0]});
         QT_S8:   ival = $signed({{9{load_word[7]}}, load_word[7:0]});
         QT_U16:  ival = $signed({1'b0, load_word[15:0]});
         default: ival = $signed({load_word[15], load_word[15:0]});
      endcase
      ineg = ival[16];
      iabs = ineg ? 17'(-ival) : 17'(ival);
      imag = iabs[15:0];
      ip   = msb23({7'd0, imag});
      kval = -$signed({ctl.scale[5], ctl.scale});
      iexp = 11'd1023 + {6'd0, ip} + {{4{kval[6]}}, kval};
      ish  = {37'd0, imag} << (6'd52 - {1'b0, ip});
      idbl = (imag == 16'd0) ? 64'd0 : {ineg, iexp, ish[51:0]};
   end

   // load, float type
   always_comb begin
      lex  = load_word[30:23];
      lman = load_word[22:0];
      lp   = msb23(lman);
      lsh  = {30'd0, lman} << (6'd52 - {1'b0, lp});
      if (lex == 8'hFF) begin
         fdbl = {load_word[31], 11'h7FF, lman, 29'd0};
      end else if (lex == 8'd0) begin
         fdbl = (lman == 23'd0) ? {load_word[31], 63'd0}
                                : {load_word[31], 11'd874 + {6'd0, lp}, lsh[51:0]};
      end else begin
         fdbl = {load_word[31], {3'd0, lex} + 11'd896, lman, 29'd0};
      end
   end

   // store
   always_comb begin
      snan  = (store_val[62:52] == 11'h7FF) && (store_val[51:0] != 52'd0);
      sflt  = dbl_to_flt(store_val);
      fword = snan ? {store_val[63], 8'hFF, 1'b1, store_val[50:29]} : sflt;
      ue    = $signed({2'b00, sflt[30:23]}) - 10'sd127 + {{4{ctl.scale[5]}}, ctl.scale};
      huge  = (sflt[30:23] == 8'hFF) || (ue > 10'sd15);
      tiny  = (sflt[30:23] == 8'd0) || (ue < 10'sd0);
      sig   = {1'b1, sflt[22:0]};
      shamt = 5'd23 - ue[4:0];
      msh   = sig >> shamt;
      smag  = tiny ? 16'd0 : msh[15:0];
      sneg  = sflt[31];
      case (ctl.qtype)
         QT_U8: begin
            if (sneg) iword = 16'd0;
            else if (huge || smag > 16'd255) iword = 16'd255;
            else iword = smag;
         end
         QT_U16: begin
            if (sneg) iword = 16'd0;
            else if (huge) iword = 16'hFFFF;
            else iword = smag;
         end
         QT_S8: begin
            if (!sneg && (huge || smag > 16'd127)) iword = 16'd127;
            else if (sneg && (huge || smag > 16'd128)) iword = 16'hFF80;
            else iword = sneg ? 16'(-smag) : smag;
         end
         default: begin
            if (!sneg && (huge || smag > 16'd32767)) iword = 16'd32767;
            else if (sneg && (huge || smag > 16'd32768)) iword = 16'h8000;
            else iword = sneg ? 16'(-smag) : smag;
         end
      endcase
   end

   always_comb begin
      res = '0;
      if (ctl.store) begin
         res.word = (ctl.qtype == QT_FLOAT) ? fword : {16'd0, iword};
         res.nan  = snan;
      end else begin
         res.dbl = (ctl.qtype == QT_FLOAT) ? fdbl : idbl;
      end
   end

endmodule

`default_nettype wire

### rtl/psq_merge.sv
// ----------------------------------------------------------------------------
// psq_merge
// Combines the two lane results into one response transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_merge (
   input  psq_pkg::psq_req_type      req,
   input  logic [31:0]               qreg,
   input  psq_pkg::psq_lane_res_type lane0,
   input  psq_pkg::psq_lane_res_type lane1,
   output psq_pkg::psq_rsp_type      rsp
);
   import psq_pkg::*;

   logic [2:0] qtype;
   logic       bad_type;
   logic       wide;
   logic       one;

   always_comb begin
      qtype    = (req.cmd == CMD_STORE) ? qreg[2:0] : qreg[18:16];
      bad_type = (qtype[2] == 1'b0) && (qtype != QT_FLOAT);
      wide     = (qtype == QT_U16) || (qtype == QT_S16);
      one      = req.single_value;
      rsp = '0;
      rsp.dest_index     = req.fpr_index;
      rsp.access_address = req.address;
      if (bad_type) begin
         rsp.fault_code = ERR_TYPE;
      end else if (req.cmd == CMD_LOAD) begin
         rsp.first_out  = lane0.dbl;
         rsp.second_out = one ? DBL_ONE : lane1.dbl;
      end else if (qtype == QT_FLOAT) begin
         rsp.store_data  = {lane0.word, one ? 32'd0 : lane1.word};
         rsp.store_bytes = one ? 4'd4 : 4'd8;
      end else if (lane0.nan || (!one && lane1.nan)) begin
         rsp.fault_code = ERR_NAN;
      end else if (wide) begin
         rsp.store_data  = {lane0.word[15:0], one ? 16'd0 : lane1.word[15:0], 32'd0};
         rsp.store_bytes = one ? 4'd2 : 4'd4;
      end else begin
         rsp.store_data  = {lane0.word[7:0], one ? 8'd0 : lane1.word[7:0], 48'd0};
         rsp.store_bytes = one ? 4'd1 : 4'd2;
      end
   end

endmodule

`default_nettype wire

### rtl/paired_single_quantizer.sv
// ----------------------------------------------------------------------------
// paired_single_quantizer
// Quantized paired-single load and store conversion, two value lanes.
//
// A transaction is taken on any cycle with start high and busy low (busy is
// high only during reset). Its response passes the input register, the two
// conversion lanes and the merge logic, and the output register, and appears
// for one cycle with rsp_strobe; the receiver cannot stall, and one
// transaction per cycle is sustained.
// ----------------------------------------------------------------------------
`default_nettype none

module paired_single_quantizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  psq_pkg::psq_req_type                  req_payload,
   input  logic                                  csr_write_en,
   input  logic [psq_pkg::QSEL_WIDTH-1:0]        csr_index,
   input  logic [31:0]                           csr_data,
   output logic                                  rsp_strobe,
   output psq_pkg::psq_rsp_type                  rsp_payload
);
   import psq_pkg::*;

   logic [31:0]      qreg_ff [NUM_QREGS];
   psq_req_type      req_ff;
   logic [31:0]      q_ff;
   logic             s1_valid_ff;
   psq_rsp_type      rsp_ff;
   logic             rsp_valid_ff;

   logic             accept;
   psq_lane_ctl_type ctl;
   logic [31:0]      word0;
   logic [31:0]      word1;
   psq_lane_res_type res0;
   psq_lane_res_type res1;
   psq_rsp_type      rsp_in;
   logic [2:0]       qtype;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QREGS; i++) begin
            qreg_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         qreg_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
         q_ff   <= qreg_ff[req_payload.quant_select];
      end
      if (s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      ctl.store = (req_ff.cmd == CMD_STORE);
      qtype     = ctl.store ? q_ff[2:0] : q_ff[18:16];
      ctl.qtype = qtype;
      ctl.scale = ctl.store ? $signed(q_ff[13:8]) : $signed(q_ff[29:24]);
      case (qtype)
         QT_U16, QT_S16: begin
            word0 = {16'd0, req_ff.load_data[63:48]};
            word1 = {16'd0, req_ff.load_data[47:32]};
         end
         QT_U8, QT_S8: begin
            word0 = {24'd0, req_ff.load_data[63:56]};
            word1 = {24'd0, req_ff.load_data[55:48]};
         end
         default: begin
            word0 = req_ff.load_data[63:32];
            word1 = req_ff.load_data[31:0];
         end
      endcase
   end

   psq_lane u_lane0 (
      .ctl       (ctl),
      .load_word (word0),
      .store_val (req_ff.first_in),
      .res       (res0)
   );

   psq_lane u_lane1 (
      .ctl       (ctl),
      .load_word (word1),
      .store_val (req_ff.second_in),
      .res       (res1)
   );

   psq_merge u_merge (
      .req   (req_ff),
      .qreg  (q_ff),
      .lane0 (res0),
      .lane1 (res1),
      .rsp   (rsp_in)
   );

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept, 2))
      else $error("response strobe does not follow accepted transaction");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.fault_code != ERR_NONE) |->
      (rsp_payload.store_bytes == 4'd0 && rsp_payload.first_out == 64'd0))
      else $error("error response carries data");

   a_store_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.store_bytes != 4'd0) |->
      ($past(req_payload.cmd, 2) == CMD_STORE))
      else $error("store bytes on a load transaction");

   a_load_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_payload.cmd, 2) == CMD_STORE) |->
      (rsp_payload.second_out == 64'd0))
      else $error("load data on a store transaction");

endmodule

`default_nettype wire

### dv/psq_result_checker.sv
// ----------------------------------------------------------------------------
// psq_result_checker
// Watches the request, response and register-write ports of the paired-single
// quantizer, predicts each response bit for bit from a shadow copy of the
// quantization registers, and compares every response field with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_result_checker
   import psq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  psq_req_type           req_payload,
   input  logic                  csr_write_en,
   input  logic [QSEL_WIDTH-1:0] csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  rsp_strobe,
   input  psq_rsp_type           rsp_payload,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] qreg_shadow [NUM_QREGS];
   psq_rsp_type predicted_rsp_q [$];

   assign pending = predicted_rsp_q.size();

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int scale_of(input logic [5:0] s);
      return s[5] ? int'(s) - 64 : int'(s);
   endfunction

   // single to double widening, subnormals normalized, nan payload kept
   function automatic logic [63:0] widen_single(input logic [31:0] f);
      logic [23:0] man;
      int          e;
      man = {1'b0, f[22:0]};
      if (f[30:23] == 8'hFF)
         return {f[31], 11'h7FF, f[22:0], 29'd0};
      if (f[30:23] == 8'd0) begin
         if (man == 0)
            return {f[31], 63'd0};
         e = 1;
         while (!man[23]) begin
            man = man << 1;
            e--;
         end
      end else begin
         e = int'(f[30:23]);
      end
      return {f[31], 11'(e - 127 + 1023), man[22:0], 29'd0};
   endfunction

   // double to single, round to nearest even; optional flush of subnormals
   function automatic logic [31:0] narrow_double(input logic [63:0] d, input bit flush);
      logic        sgn;
      logic [63:0] sig;
      logic [63:0] keep;
      logic [63:0] rest;
      logic [63:0] half;
      logic [24:0] k25;
      int          e;
      int          sh;
      bit          up;
      sgn = d[63];
      if (d[62:52] == 11'h7FF) begin
         if (d[51:0] != 0)
            return {sgn, 8'hFF, d[51:29] | 23'h400000};
         return {sgn, 8'hFF, 23'd0};
      end
      if (d[62:52] == 0)
         return {sgn, 31'd0};
      e = int'(d[62:52]) - 1023;
      sig = {11'd0, 1'b1, d[51:0]};
      if (e >= -126) begin
         rest = {35'd0, sig[28:0]};
         up = (rest > 64'h1000_0000) || (rest == 64'h1000_0000 && sig[29]);
         k25 = {1'b0, sig[52:29]} + 25'(up);
         if (k25[24]) begin
            e++;
            k25 = 25'd0;
         end
         if (e > 127)
            return {sgn, 8'hFF, 23'd0};
         return {sgn, 8'(e + 127), k25[22:0]};
      end
      sh = -97 - e;
      if (sh > 60)
         return {sgn, 31'd0};
      keep = sig >> sh;
      rest = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      up = (rest > half) || (rest == half && keep[0]);
      keep = keep + 64'(up);
      if (flush && keep < 64'h80_0000)
         return {sgn, 31'd0};
      return {sgn, keep[30:0]};
   endfunction

   // integer times a power of two as an exact double
   function automatic logic [63:0] scaled_int_to_double(input int v, input int k);
      logic [63:0] m;
      int          p;
      if (v == 0)
         return 64'd0;
      m = 64'(v < 0 ? -v : v);
      p = 0;
      for (int i = 0; i < 32; i++)
         if (m[i])
            p = i;
      m = m << (52 - p);
      return {v < 0, 11'(1023 + p + k), m[51:0]};
   endfunction

   // double to clamped integer of the store type; returns 0 on nan
   function automatic bit quantize_lane(input logic [63:0] d, input logic [2:0] t,
                                        input int s, output logic [31:0] res);
      logic [31:0] f;
      logic [63:0] sig;
      longint      mag;
      longint      val;
      longint      lo;
      longint      hi;
      int          e;
      int          sh;
      res = 0;
      f = narrow_double(d, 1'b0);
      if (f[30:23] == 8'hFF && f[22:0] != 0)
         return 1'b0;
      if (f[30:23] == 8'hFF) begin
         mag = 64'd1 << 20;
      end else if (f[30:23] == 0) begin
         mag = 0;
      end else begin
         e = int'(f[30:23]) - 127;
         sig = {40'd0, 1'b1, f[22:0]};
         sh = e - 23 + s;
         if (e + s >= 17)
            mag = 64'd1 << 20;
         else if (sh >= 0)
            mag = longint'(sig << sh);
         else if (-sh >= 40)
            mag = 0;
         else
            mag = longint'(sig >> (-sh));
      end
      val = f[31] ? -mag : mag;
      case (t)
         QT_U8: begin
            lo = 0;
            hi = 255;
         end
         QT_U16: begin
            lo = 0;
            hi = 65535;
         end
         QT_S8: begin
            lo = -128;
            hi = 127;
         end
         default: begin
            lo = -32768;
            hi = 32767;
         end
      endcase
      if (val < lo)
         val = lo;
      if (val > hi)
         val = hi;
      res = 32'(val);
      return 1'b1;
   endfunction

   function automatic psq_rsp_type predict_quantized_access(input psq_req_type r);
      psq_rsp_type p;
      logic [31:0] q;
      logic [2:0]  t;
      logic [31:0] a;
      logic [31:0] b;
      int          v0;
      int          v1;
      int          s;
      bit          ok;
      q = qreg_shadow[r.quant_select];
      p = '0;
      p.dest_index = r.fpr_index;
      p.access_address = r.address;
      p.fault_code = ERR_NONE;
      a = 0;
      b = 0;
      if (r.cmd == CMD_LOAD) begin
         t = q[18:16];
         s = -scale_of(q[29:24]);
         if (t == QT_FLOAT) begin
            p.first_out = widen_single(r.load_data[63:32]);
            p.second_out = widen_single(r.load_data[31:0]);
         end else if (t >= QT_U8) begin
            if (t == QT_U16 || t == QT_S16) begin
               v0 = int'(r.load_data[63:48]);
               v1 = int'(r.load_data[47:32]);
               if (t == QT_S16) begin
                  v0 = int'($signed(r.load_data[63:48]));
                  v1 = int'($signed(r.load_data[47:32]));
               end
            end else begin
               v0 = int'(r.load_data[63:56]);
               v1 = int'(r.load_data[55:48]);
               if (t == QT_S8) begin
                  v0 = int'($signed(r.load_data[63:56]));
                  v1 = int'($signed(r.load_data[55:48]));
               end
            end
            p.first_out = scaled_int_to_double(v0, s);
            p.second_out = scaled_int_to_double(v1, s);
         end else begin
            p.fault_code = ERR_TYPE;
         end
         if (p.fault_code == ERR_NONE && r.single_value)
            p.second_out = DBL_ONE;
      end else begin
         t = q[2:0];
         s = scale_of(q[13:8]);
         if (t == QT_FLOAT) begin
            p.store_data = {narrow_double(r.first_in, 1'b1), 32'd0};
            p.store_bytes = 4'd4;
            if (!r.single_value) begin
               p.store_data[31:0] = narrow_double(r.second_in, 1'b1);
               p.store_bytes = 4'd8;
            end
         end else if (t >= QT_U8) begin
            ok = quantize_lane(r.first_in, t, s, a);
            if (ok && !r.single_value)
               ok = quantize_lane(r.second_in, t, s, b);
            if (!ok) begin
               p.fault_code = ERR_NAN;
            end else if (t == QT_U16 || t == QT_S16) begin
               p.store_data = {a[15:0], r.single_value ? 16'd0 : b[15:0], 32'd0};
               p.store_bytes = r.single_value ? 4'd2 : 4'd4;
            end else begin
               p.store_data = {a[7:0], r.single_value ? 8'd0 : b[7:0], 48'd0};
               p.store_bytes = r.single_value ? 4'd1 : 4'd2;
            end
         end else begin
            p.fault_code = ERR_TYPE;
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      psq_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_QREGS; i++)
            qreg_shadow[i] <= 32'd0;
      end else begin
         if (rsp_strobe) begin
            if (predicted_rsp_q.size() == 0) begin
               report_mismatch("response with no transaction outstanding", 64'd1, 64'd0);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_payload.dest_index !== want.dest_index)
                  report_mismatch("dest_index", 64'(rsp_payload.dest_index),
                                  64'(want.dest_index));
               if (rsp_payload.access_address !== want.access_address)
                  report_mismatch("access_address", 64'(rsp_payload.access_address),
                                  64'(want.access_address));
               if (rsp_payload.first_out !== want.first_out)
                  report_mismatch("first_out", rsp_payload.first_out, want.first_out);
               if (rsp_payload.second_out !== want.second_out)
                  report_mismatch("second_out", rsp_payload.second_out, want.second_out);
               if (rsp_payload.store_data !== want.store_data)
                  report_mismatch("store_data", rsp_payload.store_data, want.store_data);
               if (rsp_payload.store_bytes !== want.store_bytes)
                  report_mismatch("store_bytes", 64'(rsp_payload.store_bytes),
                                  64'(want.store_bytes));
               if (rsp_payload.fault_code !== want.fault_code)
                  report_mismatch("fault_code", 64'(rsp_payload.fault_code),
                                  64'(want.fault_code));
            end
         end
         if (start && !busy)
            predicted_rsp_q = {predicted_rsp_q, predict_quantized_access(req_payload)};
         if (csr_write_en)
            qreg_shadow[csr_index] <= csr_data;
      end
   end

endmodule

`default_nettype wire

### dv/tb_paired_single_quantizer.sv
// ----------------------------------------------------------------------------
// tb_paired_single_quantizer
// Drives directed and random quantized loads and stores through the
// paired-single quantizer under several register settings, with random idle
// gaps, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_paired_single_quantizer;
   import psq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   psq_req_type           req_payload;
   logic                  csr_write_en;
   logic [QSEL_WIDTH-1:0] csr_index;
   logic [31:0]           csr_data;
   logic                  rsp_strobe;
   psq_rsp_type           rsp_payload;
   int                    fail_count;
   int                    pending;
   int                    cycle_count;

   paired_single_quantizer u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload)
   );

   psq_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("paired_single_quantizer regression: fail");
         $finish;
      end
   end

   task automatic write_qreg(input int idx, input logic [31:0] value);
      @(negedge clock);
      start = 1'b0;
      csr_write_en = 1'b1;
      csr_index = QSEL_WIDTH'(idx);
      csr_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   function automatic psq_req_type random_payload();
      logic [255:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      return raw[$bits(psq_req_type)-1:0];
   endfunction

   function automatic int idle_gap(input bit busy_phase);
      int r;
      r = $urandom_range(0, 99);
      if (!busy_phase || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic issue(input psq_req_type r, input bit gaps);
      int g;
      @(negedge clock);
      start = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      g = idle_gap(gaps);
      if (g > 0) begin
         @(negedge clock);
         start = 1'b0;
         req_payload = random_payload();
         repeat (g - 1) @(negedge clock);
      end
   endtask

   function automatic logic [2:0] pick_qtype();
      int r;
      r = $urandom_range(0, 11);
      if (r < 2)
         return QT_FLOAT;
      if (r < 4)
         return QT_U8;
      if (r < 6)
         return QT_U16;
      if (r < 8)
         return QT_S8;
      if (r < 10)
         return QT_S16;
      return 3'($urandom_range(1, 3));
   endfunction

   function automatic logic [5:0] pick_scale();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 6'h1F;
      if (r == 1)
         return 6'h20;
      if (r < 6)
         return 6'($urandom_range(0, 8)) ^ ($urandom_range(0, 1) ? 6'h3F : 6'h00);
      return 6'($urandom);
   endfunction

   function automatic logic [31:0] random_qreg();
      logic [31:0] v;
      v = $urandom;
      v[2:0] = pick_qtype();
      v[13:8] = pick_scale();
      v[18:16] = pick_qtype();
      v[29:24] = pick_scale();
      return v;
   endfunction

   function automatic logic [63:0] random_double();
      logic [63:0] d;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0: d[62:52] = 11'h7FF;
         1: begin
            d[62:52] = 11'h7FF;
            d[51:0] = 0;
         end
         2: d[62:0] = 0;
         3: d[62:52] = 11'($urandom_range(1023 - 152, 1023 - 120));
         4: begin
            d[62:52] = 11'($urandom_range(1023 + 120, 1023 + 130));
            d[28:0] = 29'h1000_0000;
         end
         5: d[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h0FFF_FFFF;
         6: d[62:52] = 11'($urandom_range(0, 1) ? 0 : 2047 - $urandom_range(1, 3));
         default: d[62:52] = 11'($urandom_range(1023 - 40, 1023 + 40));
      endcase
      return d;
   endfunction

   function automatic psq_req_type random_access();
      psq_req_type r;
      logic [31:0] w;
      r = random_payload();
      r.first_in = random_double();
      r.second_in = random_double();
      if ($urandom_range(0, 5) == 0) begin
         w = $urandom;
         w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         r.load_data[63:32] = w;
         w = $urandom;
         w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         r.load_data[31:0] = w;
      end
      return r;
   endfunction

   function automatic psq_req_type make_access(input logic c, input logic sv,
                                               input int qs, input logic [63:0] ld,
                                               input logic [63:0] f0,
                                               input logic [63:0] f1);
      psq_req_type r;
      r.cmd = c;
      r.single_value = sv;
      r.quant_select = 3'(qs);
      r.fpr_index = 5'($urandom);
      r.address = $urandom;
      r.load_data = ld;
      r.first_in = f0;
      r.second_in = f1;
      return r;
   endfunction

   initial begin
      logic [31:0] setting;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fixed types, extreme scales on registers 6 and 7, invalid types on 5
      write_qreg(0, 32'h0000_0000);
      write_qreg(1, 32'h0004_0004);
      write_qreg(2, 32'h0005_0005);
      write_qreg(3, 32'h0006_0006);
      write_qreg(4, 32'h0007_0007);
      write_qreg(5, 32'hC2C1_C3C2);
      write_qreg(6, 32'h2007_1F07);
      write_qreg(7, 32'h1F04_2004);

      issue(make_access(CMD_LOAD, 1'b0, 0, 64'h3F80_0000_FFC0_0001, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 0, 64'h0000_0001_807F_FFFF, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b1, 0, 64'h7F80_0000_1234_5678, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 1, 64'hFF00_0000_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 2, 64'hFFFF_0001_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 3, 64'h807F_0000_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b1, 4, 64'h8000_7FFF_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 6, 64'h8000_7FFF_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 7, 64'hFF01_0000_0000_0000, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_LOAD, 1'b0, 5, '1, 64'd0, 64'd0), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 0, 64'd0, 64'h3FF0_0000_1000_0000,
                        64'h47F0_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 0, 64'd0, 64'h7FF0_0000_0000_0001,
                        64'h380F_FFFF_F000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b1, 0, 64'd0, 64'h8000_0000_0000_0000, '1), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 1, 64'd0, 64'hC000_0000_0000_0000,
                        64'h4070_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 2, 64'd0, 64'h40EF_FFE0_0000_0000,
                        64'h3FE0_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 3, 64'd0, 64'hC060_2000_0000_0000,
                        64'hBFEF_FFFF_FFFF_FFFF), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 4, 64'd0, 64'hFFF0_0000_0000_0000,
                        64'h7FF0_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 4, 64'd0, 64'h3FF0_0000_0000_0000,
                        64'hFFF8_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b1, 4, 64'd0, 64'h40DF_FFC0_0000_0000,
                        64'h7FF8_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 6, 64'd0, 64'h3E00_0000_0000_0000,
                        64'h3FF0_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 7, 64'd0, 64'h4200_0000_0000_0000,
                        64'h4210_0000_0000_0000), 1'b0);
      issue(make_access(CMD_STORE, 1'b0, 5, 64'd0, 64'h7FF8_0000_0000_0000, 64'd0), 1'b0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i < NUM_QREGS; i++) begin
            setting = random_qreg();
            if (phase == 1)
               setting = 32'hFFFF_FFFF;
            else if (phase == 2)
               setting = 32'h0000_0000;
            write_qreg(i, setting);
         end
         repeat (phase == 1 || phase == 2 ? 40 : 140)
            issue(random_access(), phase != 3);
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("paired_single_quantizer regression: pass");
      else
         $display("paired_single_quantizer regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### paired_single_quantizer.f
rtl/psq_pkg.sv
rtl/psq_lane.sv
rtl/psq_merge.sv
rtl/paired_single_quantizer.sv
dv/psq_result_checker.sv
dv/tb_paired_single_quantizer.sv
